>>> sv/quic_varint_frame_deframer_top_defines.svh
// assertion macros used by the top-level module
`ifndef QUIC_VARINT_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define QUIC_VARINT_FRAME_DEFRAMER_TOP_DEFINES_SVH

// same-cycle implication
`define QVD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qvd implication check failed");

// next-cycle implication
`define QVD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qvd next-cycle check failed");

`endif

>>> sv/qvd_pkg.sv
package qvd_pkg;

    localparam int VW = 62;
    localparam int BW = 8;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2
    } qvd_phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TRUNC   = 2'd2
    } qvd_kind_t;

    typedef struct packed {
        logic [BW-1:0] data_byte;
        logic          end_of_data;
    } in_item_t;

    typedef struct packed {
        qvd_kind_t     kind;
        logic [VW-1:0] frame_type;
        logic [VW-1:0] payload_length;
        logic [BW-1:0] payload_byte;
        logic          last_of_frame;
        logic          truncated;
    } out_item_t;

    // classified byte as queued between front and back
    typedef struct packed {
        logic [BW-1:0] data_byte;
        logic          end_of_data;
        logic [2:0]    first_extra;
    } qvd_entry_t;

    typedef struct packed {
        logic       valid;
        qvd_entry_t entry;
    } qvd_queue_t;

    // bytes after the first one, from the varint length prefix
    function automatic logic [2:0] varint_extra(input logic [1:0] prefix);
        logic [2:0] n;
        case (prefix)
            2'd0:    n = 3'd0;
            2'd1:    n = 3'd1;
            2'd2:    n = 3'd3;
            default: n = 3'd7;
        endcase
        return n;
    endfunction

endpackage

>>> sv/qvd_front.sv
module qvd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qvd_pkg::in_item_t  in_data,
    output qvd_pkg::qvd_queue_t q,
    input  logic               pop
);

    qvd_pkg::qvd_entry_t mem [qvd_pkg::QDEPTH];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push;
    qvd_pkg::qvd_entry_t cls;

    assign in_ready = (count_reg != 2'(qvd_pkg::QDEPTH));
    assign push     = in_valid && in_ready;

    always_comb
    begin
        cls.data_byte   = in_data.data_byte;
        cls.end_of_data = in_data.end_of_data;
        cls.first_extra = qvd_pkg::varint_extra(in_data.data_byte[7:6]);
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    assign q.valid = (count_reg != 2'd0);
    assign q.entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

>>> sv/qvd_back.sv
module qvd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  qvd_pkg::qvd_queue_t q,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output qvd_pkg::out_item_t  out_data
);

    qvd_pkg::qvd_phase_t        phase_reg, phase_next;
    logic [2:0]                 vbl_reg, vbl_next;
    logic [qvd_pkg::VW-1:0]     acc_reg, acc_next;
    logic [qvd_pkg::VW-1:0]     ftype_reg, ftype_next;
    logic [qvd_pkg::VW-1:0]     plen_reg, plen_next;
    logic [qvd_pkg::VW-1:0]     pbl_reg, pbl_next;
    logic                       out_valid_reg, out_valid_next;
    qvd_pkg::out_item_t         out_reg, out_next;

    logic [qvd_pkg::BW-1:0]     b;
    logic                       eod;
    logic [qvd_pkg::VW-1:0]     pdec;
    logic                       plast;
    logic                       emit;
    qvd_pkg::qvd_kind_t         ekind;
    logic [qvd_pkg::BW-1:0]     ebyte;
    logic                       elast;
    logic                       etrunc;
    logic                       restart;
    logic                       is_len;

    assign pop       = q.valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign b         = q.entry.data_byte;
    assign eod       = q.entry.end_of_data;
    assign pdec      = (pbl_reg != '0) ? pbl_reg - qvd_pkg::VW'(1) : '0;
    assign plast     = (pdec == '0);

    always_comb
    begin
        phase_next = phase_reg;
        vbl_next   = vbl_reg;
        acc_next   = acc_reg;
        ftype_next = ftype_reg;
        plen_next  = plen_reg;
        pbl_next   = pbl_reg;
        emit       = 1'b0;
        ekind      = qvd_pkg::KIND_HEADER;
        ebyte      = '0;
        elast      = 1'b0;
        etrunc     = 1'b0;
        restart    = 1'b0;
        is_len     = (phase_reg == qvd_pkg::PH_LEN);

        case (phase_reg)
            qvd_pkg::PH_PAY:
            begin
                emit     = 1'b1;
                ekind    = qvd_pkg::KIND_PAYLOAD;
                ebyte    = b;
                elast    = plast;
                etrunc   = eod && !plast;
                pbl_next = pdec;
                restart  = plast || eod;
            end
            default:
            begin
                if (vbl_reg == 3'd0)
                begin
                    if (!is_len)
                    begin
                        ftype_next = '0;
                        plen_next  = '0;
                    end
                    acc_next = qvd_pkg::VW'(b[5:0]);
                    vbl_next = q.entry.first_extra;
                end
                else
                begin
                    acc_next = {acc_reg[qvd_pkg::VW-qvd_pkg::BW-1:0], b};
                    vbl_next = vbl_reg - 3'd1;
                end

                if (vbl_next == 3'd0)
                begin
                    if (!is_len)
                    begin
                        ftype_next = acc_next;
                        acc_next   = '0;
                        phase_next = qvd_pkg::PH_LEN;
                        if (eod)
                        begin
                            emit    = 1'b1;
                            ekind   = qvd_pkg::KIND_TRUNC;
                            etrunc  = 1'b1;
                            restart = 1'b1;
                        end
                    end
                    else
                    begin
                        plen_next = acc_next;
                        acc_next  = '0;
                        emit      = 1'b1;
                        ekind     = qvd_pkg::KIND_HEADER;
                        if (plen_next == '0)
                        begin
                            elast   = 1'b1;
                            restart = 1'b1;
                        end
                        else if (eod)
                        begin
                            etrunc  = 1'b1;
                            restart = 1'b1;
                        end
                        else
                        begin
                            pbl_next   = plen_next;
                            phase_next = qvd_pkg::PH_PAY;
                        end
                    end
                end
                else
                begin
                    phase_next = is_len ? qvd_pkg::PH_LEN : qvd_pkg::PH_TYPE;
                    if (eod)
                    begin
                        emit    = 1'b1;
                        ekind   = qvd_pkg::KIND_TRUNC;
                        etrunc  = 1'b1;
                        restart = 1'b1;
                    end
                end
            end
        endcase

        if (restart)
        begin
            phase_next = qvd_pkg::PH_TYPE;
            vbl_next   = 3'd0;
            acc_next   = '0;
            pbl_next   = '0;
        end

        out_next.kind           = ekind;
        out_next.frame_type     = ftype_next;
        out_next.payload_length = plen_next;
        out_next.payload_byte   = ebyte;
        out_next.last_of_frame  = elast;
        out_next.truncated      = etrunc;

        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= qvd_pkg::PH_TYPE;
            vbl_reg       <= 3'd0;
            acc_reg       <= '0;
            ftype_reg     <= '0;
            plen_reg      <= '0;
            pbl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                vbl_reg   <= vbl_next;
                acc_reg   <= acc_next;
                ftype_reg <= ftype_next;
                plen_reg  <= plen_next;
                pbl_reg   <= pbl_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/quic_varint_frame_deframer_top.sv
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    qvd_pkg::in_item_t, one stream byte
// out      out  out_valid / out_ready  qvd_pkg::out_item_t, zero or one per byte
//
// one byte per cycle sustained while out_ready stays high; out_valid rises once its byte has
// passed the two-entry byte queue and the output register of the parser
// rst_n clears the queue and the parser state at once; no clearing pass
// a stalled output holds its result and the parser stops draining the queue
// in_ready drops only when both queue entries are occupied
`include "quic_varint_frame_deframer_top_defines.svh"

module quic_varint_frame_deframer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qvd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output qvd_pkg::out_item_t out_data
);

    qvd_pkg::qvd_queue_t q;
    logic                pop;

    qvd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q        (q),
        .pop      (pop)
    );

    qvd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q         (q),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `QVD_ASSERT_IMP(a_empty_ready, !q.valid, in_ready)
    `QVD_ASSERT_NXT(a_empty_holds, !q.valid && !(in_valid && in_ready), !q.valid)
    `QVD_ASSERT_IMP(a_trunc_kind, out_valid && (out_data.kind == qvd_pkg::KIND_TRUNC), out_data.truncated && !out_data.last_of_frame)
    `QVD_ASSERT_IMP(a_byte_zero, out_valid && (out_data.kind != qvd_pkg::KIND_PAYLOAD), out_data.payload_byte == 8'd0)

endmodule

>>> dv/quic_varint_frame_deframer_top_test.sv
`timescale 1ns / 100ps

module quic_varint_frame_deframer_top_test;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    qvd_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    qvd_pkg::out_item_t out_data;

    quic_varint_frame_deframer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // parser state as predicted
    qvd_pkg::qvd_phase_t    pr_phase = qvd_pkg::PH_TYPE;
    logic [2:0]             pr_vleft = '0;
    logic [qvd_pkg::VW-1:0] pr_acc = '0;
    logic [qvd_pkg::VW-1:0] held_type = '0;
    logic [qvd_pkg::VW-1:0] held_len = '0;
    logic [qvd_pkg::VW-1:0] pr_pay_left = '0;

    qvd_pkg::in_item_t  bytes_to_send[$];
    qvd_pkg::out_item_t expected_results[$];
    logic [7:0] frame_buf[$];

    int n_queued = 0;
    int n_offered = 0;
    int n_accepted = 0;
    int n_predicted = 0;
    int n_checked = 0;
    int n_mismatches = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    bit hold_go = 1'b0;
    bit rcv_hold = 1'b0;

    task automatic report_mismatch(input string what);
        if (n_mismatches < 100)
            $display("mismatch at %0t ns: %s", $time, what);
        n_mismatches++;
    endtask

    function automatic void restart_frame();
        pr_phase = qvd_pkg::PH_TYPE;
        pr_vleft = '0;
        pr_acc = '0;
        pr_pay_left = '0;
    endfunction

    function automatic qvd_pkg::out_item_t make_result(input qvd_pkg::qvd_kind_t k,
                                                       input logic [7:0] pb,
                                                       input bit last, input bit trunc);
        qvd_pkg::out_item_t r;
        r.kind = k;
        r.frame_type = held_type;
        r.payload_length = held_len;
        r.payload_byte = pb;
        r.last_of_frame = last;
        r.truncated = trunc;
        return r;
    endfunction

    // returns 1 when the byte produces a result
    function automatic bit deframe_byte(input qvd_pkg::in_item_t it,
                                        output qvd_pkg::out_item_t res);
        qvd_pkg::qvd_phase_t ph;
        logic [7:0] b;
        bit eod;
        bit last;
        b = it.data_byte;
        eod = it.end_of_data;
        res = '0;
        if (pr_phase == qvd_pkg::PH_PAY) begin
            if (pr_pay_left != 0)
                pr_pay_left = pr_pay_left - 1'b1;
            last = (pr_pay_left == 0);
            res = make_result(qvd_pkg::KIND_PAYLOAD, b, last, eod && !last);
            if (last || eod)
                restart_frame();
            return 1'b1;
        end
        ph = (pr_phase == qvd_pkg::PH_LEN) ? qvd_pkg::PH_LEN : qvd_pkg::PH_TYPE;
        if (pr_vleft == 0) begin
            if (ph == qvd_pkg::PH_TYPE) begin
                held_type = '0;
                held_len = '0;
            end
            pr_acc = qvd_pkg::VW'(b[5:0]);
            pr_vleft = 3'((4'd1 << b[7:6]) - 4'd1);
        end
        else begin
            pr_acc = {pr_acc[qvd_pkg::VW-9:0], b};
            pr_vleft = pr_vleft - 3'd1;
        end
        if (pr_vleft == 0) begin
            if (ph == qvd_pkg::PH_TYPE) begin
                held_type = pr_acc;
                pr_acc = '0;
                pr_phase = qvd_pkg::PH_LEN;
                if (eod) begin
                    res = make_result(qvd_pkg::KIND_TRUNC, 8'h00, 1'b0, 1'b1);
                    restart_frame();
                    return 1'b1;
                end
                return 1'b0;
            end
            held_len = pr_acc;
            pr_acc = '0;
            if (held_len == 0) begin
                res = make_result(qvd_pkg::KIND_HEADER, 8'h00, 1'b1, 1'b0);
                restart_frame();
                return 1'b1;
            end
            res = make_result(qvd_pkg::KIND_HEADER, 8'h00, 1'b0, eod);
            if (eod)
                restart_frame();
            else begin
                pr_pay_left = held_len;
                pr_phase = qvd_pkg::PH_PAY;
            end
            return 1'b1;
        end
        pr_phase = ph;
        if (eod) begin
            res = make_result(qvd_pkg::KIND_TRUNC, 8'h00, 1'b0, 1'b1);
            restart_frame();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_result(input qvd_pkg::out_item_t got, input qvd_pkg::out_item_t want);
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.frame_type !== want.frame_type)
            report_mismatch($sformatf("frame_type got %h want %h",
                                      got.frame_type, want.frame_type));
        if (got.payload_length !== want.payload_length)
            report_mismatch($sformatf("payload_length got %h want %h",
                                      got.payload_length, want.payload_length));
        if (got.payload_byte !== want.payload_byte)
            report_mismatch($sformatf("payload_byte got %h want %h",
                                      got.payload_byte, want.payload_byte));
        if (got.last_of_frame !== want.last_of_frame)
            report_mismatch($sformatf("last_of_frame got %b want %b",
                                      got.last_of_frame, want.last_of_frame));
        if (got.truncated !== want.truncated)
            report_mismatch($sformatf("truncated got %b want %b",
                                      got.truncated, want.truncated));
    endtask

    task automatic send_byte(input logic [7:0] b, input bit eod);
        qvd_pkg::in_item_t it;
        it.data_byte = b;
        it.end_of_data = eod;
        bytes_to_send = {bytes_to_send, it};
        n_queued++;
    endtask

    // varint of 2**lg bytes into frame_buf, big-endian
    task automatic add_varint(input logic [qvd_pkg::VW-1:0] v, input int lg);
        logic [63:0] w;
        int nb;
        nb = 1 << lg;
        w = (64'(lg) << (8 * nb - 2)) | 64'(v);
        for (int i = nb - 1; i >= 0; i--)
            frame_buf = {frame_buf, w[8*i +: 8]};
    endtask

    function automatic logic [qvd_pkg::VW-1:0] rand_value(input int lg);
        logic [63:0] raw;
        logic [63:0] mask;
        raw = {$urandom, $urandom};
        mask = (64'd1 << (8 * (1 << lg) - 2)) - 64'd1;
        case ($urandom_range(3))
            0: return qvd_pkg::VW'($urandom_range(3));
            1: return mask[qvd_pkg::VW-1:0];
            default: return raw[qvd_pkg::VW-1:0] & mask[qvd_pkg::VW-1:0];
        endcase
    endfunction

    task automatic queue_random_frame();
        logic [qvd_pkg::VW-1:0] tv;
        logic [qvd_pkg::VW-1:0] lv;
        logic [7:0] rb;
        int tlg;
        int llg;
        int cut;
        bit with_eod;
        frame_buf.delete();
        tlg = $urandom_range(3);
        llg = $urandom_range(3);
        tv = rand_value(tlg);
        lv = ($urandom_range(7) == 0) ? rand_value(llg) : qvd_pkg::VW'($urandom_range(6));
        add_varint(tv, tlg);
        add_varint(lv, llg);
        repeat ((lv > 8) ? 8 : int'(lv)) begin
            rb = 8'($urandom);
            frame_buf = {frame_buf, rb};
        end
        cut = frame_buf.size();
        with_eod = ($urandom_range(9) == 0);
        // long payloads are always cut short
        if (lv > 8 || $urandom_range(7) == 0) begin
            cut = $urandom_range(frame_buf.size(), 1);
            with_eod = 1'b1;
        end
        for (int i = 0; i < cut; i++)
            send_byte(frame_buf[i], with_eod && i == cut - 1);
    endtask

    // random bytes closed by an end-of-data byte, which resyncs the parser
    task automatic queue_noise();
        int n;
        n = $urandom_range(6, 1);
        for (int i = 1; i <= n; i++)
            send_byte(8'($urandom), i == n || $urandom_range(7) == 0);
    endtask

    task automatic queue_random_stream(input int count);
        int start;
        start = n_queued;
        while (n_queued - start < count) begin
            if ($urandom_range(9) == 0)
                queue_noise();
            else
                queue_random_frame();
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (bytes_to_send.size() != 0 || in_valid || n_checked != n_predicted);
    endtask

    initial begin
        forever #4 clk = ~clk;
    end

    // input driver
    always @(negedge clk) begin
        if (rst_n && (!in_valid || n_accepted == n_offered)) begin
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                in_valid <= 1'b1;
                in_data <= bytes_to_send.pop_front();
                n_offered <= n_offered + 1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output ready
    always @(negedge clk) begin
        out_ready <= rst_n && !rcv_hold && ($urandom_range(99) >= rcv_idle_pct);
    end

    // long receiver stall while the sender keeps going
    initial begin
        wait (hold_go);
        @(negedge clk);
        rcv_hold <= 1'b1;
        repeat (300) @(negedge clk);
        rcv_hold <= 1'b0;
    end

    // monitor: predict on every input transfer, check every output transfer
    always @(posedge clk) begin
        qvd_pkg::out_item_t predicted;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                n_accepted <= n_accepted + 1;
                if (deframe_byte(in_data, predicted)) begin
                    expected_results = {expected_results, predicted};
                    n_predicted <= n_predicted + 1;
                end
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected");
                else begin
                    check_result(out_data, expected_results.pop_front());
                    n_checked <= n_checked + 1;
                end
            end
        end
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        snd_idle_pct = 22;
        rcv_idle_pct = 63;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // zero type, empty payload
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        // largest one-byte type, two payload bytes
        send_byte(8'h3f, 1'b0); send_byte(8'h02, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b0);
        // largest eight-byte type, data ends on the final payload byte
        repeat (8) send_byte(8'hff, 1'b0);
        send_byte(8'h40, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'ha5, 1'b1);
        // data ends on the header byte with payload still owed
        send_byte(8'h05, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h03, 1'b1);
        // data ends inside the type varint
        send_byte(8'h41, 1'b1);
        // data ends right after the type
        send_byte(8'h07, 1'b1);
        // data ends inside the length varint
        send_byte(8'h01, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h12, 1'b1);
        // data ends inside the payload
        send_byte(8'h07, 1'b0); send_byte(8'h05, 1'b0);
        send_byte(8'h11, 1'b0); send_byte(8'h22, 1'b1);
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            snd_idle_pct = (p == 0) ? 22 : (p == 1) ? 63 : 0;
            rcv_idle_pct = (p == 0) ? 63 : (p == 1) ? 22 : 0;
            if (p == 2)
                hold_go = 1'b1;
            for (int c = 0; c < 2; c++) begin
                queue_random_stream(225);
                wait_drained();
            end
        end

        repeat (16) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (n_mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/qvd_pkg.sv
sv/qvd_front.sv
sv/qvd_back.sv
sv/quic_varint_frame_deframer_top.sv
dv/quic_varint_frame_deframer_top_test.sv
